// ===== sv/fap_pkg.sv =====
// shared types, constants and codes of the fixed block pool allocator
package fap_pkg;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 7;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam int DEFAULT_MAX_BLOCKS = 64;

    // register reset values
    localparam logic [ADDR_W-1:0]  BASE_RST  = 32'd0;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 16'd16;
    localparam logic [COUNT_W-1:0] COUNT_RST = 7'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_BLOCK = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_RANGE = 2'd3
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic init;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
    } dp_stat_t;

endpackage

// ===== sv/fap_datapath.sv =====
// used marks, block walk and result registers of the pool allocator
module fap_datapath #(
    parameter int MAX_BLOCKS = fap_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fap_pkg::ctrl_cmd_t                ctl,
    output fap_pkg::dp_stat_t                 stat,
    input  logic [fap_pkg::CMD_W-1:0]         cmd_in,
    input  logic [fap_pkg::ADDR_W-1:0]        addr_in,
    input  logic [fap_pkg::ADDR_W-1:0]        base,
    input  logic [fap_pkg::SIZE_W-1:0]        size,
    input  logic [fap_pkg::COUNT_W-1:0]       count,
    output logic [fap_pkg::STAT_W-1:0]        status_out,
    output logic [fap_pkg::ADDR_W-1:0]        block_address_out,
    output logic                              in_pool_out,
    output logic [fap_pkg::COUNT_W-1:0]       free_count_out
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SUM_W = ((CW + fap_pkg::SIZE_W) > fap_pkg::ADDR_W)
                           ? (CW + fap_pkg::SIZE_W) : fap_pkg::ADDR_W;
    localparam int RW = SUM_W + 1;

    logic [MAX_BLOCKS-1:0]          marks_reg, marks_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic [CW-1:0]                  n_reg, n_next;
    logic [RW-1:0]                  run_reg, run_next;
    logic                           found_reg, found_next;
    logic [fap_pkg::COUNT_W-1:0]    cnt_reg, cnt_next;
    fap_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [fap_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic [fap_pkg::ADDR_W-1:0]     hit_reg, hit_next;

    logic [fap_pkg::STAT_W-1:0]     status_reg, status_next;
    logic [fap_pkg::ADDR_W-1:0]     baddr_reg, baddr_next;
    logic                           inpool_reg, inpool_next;
    logic [fap_pkg::COUNT_W-1:0]    fcount_reg, fcount_next;

    logic                           cur_used;
    logic                           alloc_hit;
    logic                           free_hit;
    logic                           new_used;
    logic [CW-1:0]                  n_calc;

    // effective block count, saturated to the pool size
    assign n_calc = (32'(count) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(count);

    assign cur_used  = marks_reg[idx_reg[IW-1:0]];
    assign alloc_hit = (cmd_reg == fap_pkg::CMD_ALLOC) && !found_reg && !cur_used;
    assign free_hit  = (cmd_reg == fap_pkg::CMD_FREE) && !found_reg
                       && (run_reg[fap_pkg::ADDR_W-1:0] == addr_reg);
    assign new_used  = alloc_hit ? 1'b1 : (free_hit ? 1'b0 : cur_used);

    assign stat.walk_done = (idx_reg == n_reg);

    always_comb
    begin
        marks_next  = marks_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        run_next    = run_reg;
        found_next  = found_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        addr_next   = addr_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        baddr_next  = baddr_reg;
        inpool_next = inpool_reg;
        fcount_next = fcount_reg;

        if (ctl.init)
        begin
            idx_next   = '0;
            n_next     = n_calc;
            run_next   = RW'(base);
            found_next = 1'b0;
            cnt_next   = '0;
            cmd_next   = fap_pkg::cmd_t'(cmd_in);
            addr_next  = addr_in;
            hit_next   = '0;
            if (fap_pkg::cmd_t'(cmd_in) == fap_pkg::CMD_CLEAR)
            begin
                marks_next = '0;
            end
        end
        else if (ctl.step)
        begin
            // one block per cycle: update its mark, then count it
            marks_next[idx_reg[IW-1:0]] = new_used;
            cnt_next = cnt_reg + fap_pkg::COUNT_W'(!new_used);
            idx_next = idx_reg + CW'(1);
            run_next = run_reg + RW'(size);
            if (alloc_hit || free_hit)
            begin
                found_next = 1'b1;
                hit_next   = run_reg[fap_pkg::ADDR_W-1:0];
            end
        end
        else if (ctl.finish)
        begin
            baddr_next  = '0;
            inpool_next = 1'b0;
            fcount_next = cnt_reg;
            case (cmd_reg)
                fap_pkg::CMD_ALLOC:
                begin
                    status_next = found_reg ? fap_pkg::ST_OK : fap_pkg::ST_FULL;
                    baddr_next  = found_reg ? hit_reg : '0;
                end
                fap_pkg::CMD_FREE:
                begin
                    status_next = found_reg ? fap_pkg::ST_OK : fap_pkg::ST_NOT_BLOCK;
                end
                fap_pkg::CMD_RANGE:
                begin
                    // run_reg now holds the unwrapped end of the pool
                    status_next = fap_pkg::ST_OK;
                    inpool_next = (addr_reg >= base) && (RW'(addr_reg) < run_reg);
                end
                default:
                begin
                    status_next = fap_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else
        begin
            marks_reg <= marks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        run_reg    <= run_next;
        found_reg  <= found_next;
        cnt_reg    <= cnt_next;
        cmd_reg    <= cmd_next;
        addr_reg   <= addr_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        baddr_reg  <= baddr_next;
        inpool_reg <= inpool_next;
        fcount_reg <= fcount_next;
    end

    assign status_out        = status_reg;
    assign block_address_out = baddr_reg;
    assign in_pool_out       = inpool_reg;
    assign free_count_out    = fcount_reg;

endmodule

// ===== sv/fap_ctrl.sv =====
// controller state machine of the pool allocator
module fap_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output fap_pkg::ctrl_cmd_t   ctl,
    input  fap_pkg::dp_stat_t    stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_RESP
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    assign ctl.init   = (state_reg == S_IDLE) && start;
    assign ctl.step   = (state_reg == S_WALK) && !stat.walk_done;
    assign ctl.finish = (state_reg == S_WALK) && stat.walk_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_WALK;
                        busy_reg  <= 1'b1;
                    end
                end
                S_WALK:
                begin
                    if (stat.walk_done)
                    begin
                        state_reg <= S_RESP;
                        done_reg  <= 1'b1;
                    end
                end
                S_RESP:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ===== sv/fixed_block_pool_allocator.sv =====
// top level of the fixed block pool allocator: config registers, controller, datapath
//
// usage
// - command channel: a beat (cmd, addr) is taken at a rising edge with start high
//   and busy low; busy stays high until the result has been shown
// - result channel: done is high for exactly one cycle while status,
//   block_address, in_pool and free_count are valid; the receiver cannot stall,
//   so the result must be taken in that cycle
// - config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high; index 0 base address, 1 block size, 2 block count, 3 is
//   ignored; write only while busy is low
// - timing: every command walks the effective block count n (min of block_count
//   and MAX_BLOCKS) one block per cycle through one address adder and one
//   compare; done rises once the walk is over, and busy drops in the cycle
//   after done
// - reset: every block free, base 0, block size 16, block count 64; no clearing
//   pass is needed, the used marks are flip-flops
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fap_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic [fap_pkg::CMD_W-1:0]         cmd,
    input  logic [fap_pkg::ADDR_W-1:0]        addr,
    // result channel
    output logic                              done,
    output logic [fap_pkg::STAT_W-1:0]        status,
    output logic [fap_pkg::ADDR_W-1:0]        block_address,
    output logic                              in_pool,
    output logic [fap_pkg::COUNT_W-1:0]       free_count,
    // config channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fap_pkg::ADDR_W-1:0]        cfg_data
);

    logic [fap_pkg::ADDR_W-1:0]   base_reg;
    logic [fap_pkg::SIZE_W-1:0]   size_reg;
    logic [fap_pkg::COUNT_W-1:0]  count_reg;

    fap_pkg::ctrl_cmd_t           ctl;
    fap_pkg::dp_stat_t            stat;

    // config writes are accepted at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= fap_pkg::BASE_RST;
            size_reg  <= fap_pkg::SIZE_RST;
            count_reg <= fap_pkg::COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fap_pkg::REG_BASE:  base_reg  <= cfg_data;
                fap_pkg::REG_SIZE:  size_reg  <= cfg_data[fap_pkg::SIZE_W-1:0];
                fap_pkg::REG_COUNT: count_reg <= cfg_data[fap_pkg::COUNT_W-1:0];
                default:
                begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // sequencing: idle, walk over the blocks, one cycle of result
    fap_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl),
        .stat  (stat)
    );

    // used marks, running block address, free counter and result registers
    fap_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .stat              (stat),
        .cmd_in            (cmd),
        .addr_in           (addr),
        .base              (base_reg),
        .size              (size_reg),
        .count             (count_reg),
        .status_out        (status),
        .block_address_out (block_address),
        .in_pool_out       (in_pool),
        .free_count_out    (free_count)
    );

    // a result only shows up while a command is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a command");

    // an accepted command holds busy in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // free count never exceeds the configured block count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (free_count <= count_reg))
        else $error("free count above block count");

    // a full pool has no free block left
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == fap_pkg::ST_FULL)) |-> (free_count == '0))
        else $error("pool full reported with free blocks");

    // the result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule
